// ===== hdl/qmn_pkg.sv =====
// ----------------------------------------------------------------------------
// qmn_pkg: shared types and constants for the normalized quaternion product
// Holds the pipeline stage bookkeeping types and fixed field widths.
// ----------------------------------------------------------------------------
package qmn_pkg;

  // Width of one payload field on the ports
  localparam int FieldW = 32;
  // Width of an exact component product sum
  localparam int ProdW  = 64;
  // Magnitude width after block scaling
  localparam int MagW   = 31;
  // Width of the squared-norm sum
  localparam int SumW   = 64;
  // Width of the root
  localparam int RootW  = 32;

  // Integer square root of a 64-bit value, one result bit per stage
  localparam int SqrtSteps = 32;

  // Sign and zero marks that ride along with the magnitudes
  typedef struct packed {
    logic [3:0] neg;
    logic       zero;
  } qmn_flags_t;

endpackage

// ===== hdl/qmn_product.sv =====
// ----------------------------------------------------------------------------
// qmn_product: Hamilton product with block scaling
// Stage 1 registers the sixteen partial products, stage 2 the four sums,
// stage 3 the signs and magnitudes, stage 4 the scaled magnitudes.
// ----------------------------------------------------------------------------
module qmn_product import qmn_pkg::*; #(
  parameter int CompW = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [8*FieldW-1:0]     in_data,
  output logic                    out_valid,
  output logic [4*MagW-1:0]       mag,
  output qmn_flags_t              flags
);

  logic signed [CompW-1:0]   a [4];
  logic signed [CompW-1:0]   b [4];
  logic signed [2*CompW-1:0] pp [16];
  logic signed [ProdW-1:0]   psum [4];
  logic signed [ProdW-1:0]   t [16];
  logic [ProdW-1:0]          m3 [4];
  logic [3:0]                neg3;
  logic [6:0]                blen;
  logic [ProdW-1:0]          maxm;
  logic [3:0]                v;

  // Take the low component bits of each field
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a[i] = in_data[i*FieldW +: CompW];
      b[i] = in_data[(i+4)*FieldW +: CompW];
    end
  end

  // Stage 1: partial products, index 4*i+j holds a[i]*b[j]
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          pp[4*i+j] <= a[i] * b[j];
    end
  end

  // Floor divide by four of each sign-extended product
  always_comb begin
    for (int k = 0; k < 16; k++)
      t[k] = ProdW'(pp[k]) >>> 2;
  end

  // Stage 2: the four Hamilton sums
  always_ff @(posedge clk) begin
    if (en) begin
      psum[0] <= t[0]  - t[5]  - t[10] - t[15];
      psum[1] <= t[1]  + t[4]  + t[11] - t[14];
      psum[2] <= t[2]  - t[7]  + t[8]  + t[13];
      psum[3] <= t[3]  + t[6]  - t[9]  + t[12];
    end
  end

  // Stage 3: signs and magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        neg3[i] <= psum[i][ProdW-1];
        m3[i]   <= psum[i][ProdW-1] ? (~psum[i] + 1'b1) : psum[i];
      end
    end
  end

  // Bit length of the largest magnitude, found on the OR of all four
  always_comb begin
    maxm = m3[0] | m3[1] | m3[2] | m3[3];
    blen = '0;
    for (int k = 0; k < ProdW; k++)
      if (maxm[k]) blen = 7'(k + 1);
  end

  // Stage 4: shift so the largest magnitude has exactly MagW bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (blen < 7'(MagW))
          mag[i*MagW +: MagW] <= MagW'(m3[i] << (7'(MagW) - blen));
        else
          mag[i*MagW +: MagW] <= MagW'(m3[i] >> (blen - 7'(MagW)));
      end
      flags.neg  <= neg3;
      flags.zero <= (blen == '0);
    end
  end

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end
  assign out_valid = v[3];

endmodule

// ===== hdl/qmn_sqrt.sv =====
// ----------------------------------------------------------------------------
// qmn_sqrt: squared norm and pipelined integer square root
// Squares the scaled magnitudes, sums them, then resolves one root bit per
// stage by restoring subtraction while the magnitudes ride alongside.
// ----------------------------------------------------------------------------
module qmn_sqrt import qmn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [4*MagW-1:0]  in_mag,
  input  qmn_flags_t         in_flags,
  output logic               out_valid,
  output logic [4*MagW-1:0]  mag,
  output qmn_flags_t         flags,
  output logic [RootW-1:0]   root
);

  localparam int Depth = SqrtSteps + 2;

  logic [2*MagW-1:0] sq [4];
  logic [4*MagW-1:0] smag;
  qmn_flags_t        sflags;
  logic [SumW-1:0]   rem [SqrtSteps+1];
  logic [RootW-1:0]  res [SqrtSteps+1];
  logic [4*MagW-1:0] pm  [SqrtSteps+1];
  qmn_flags_t        pf  [SqrtSteps+1];
  logic [Depth-1:0]  v;

  // Squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++)
        sq[i] <= in_mag[i*MagW +: MagW] * in_mag[i*MagW +: MagW];
      smag   <= in_mag;
      sflags <= in_flags;
    end
  end

  // Sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]) + SumW'(sq[3]);
      res[0] <= '0;
      pm[0]  <= smag;
      pf[0]  <= sflags;
    end
  end

  // One root bit per stage, most significant first
  for (genvar s = 0; s < SqrtSteps; s++) begin : g_step
    localparam int Bit = SqrtSteps - 1 - s;
    logic [SumW+1:0] trial;
    assign trial = {2'b0, rem[s]} -
                   ({2'b0, SumW'(res[s]) << (Bit + 1)} | (66'd1 << (2 * Bit)));
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[SumW+1]) begin
          rem[s+1] <= trial[SumW-1:0];
          res[s+1] <= res[s] | (RootW'(1) << Bit);
        end else begin
          rem[s+1] <= rem[s];
          res[s+1] <= res[s];
        end
        pm[s+1] <= pm[s];
        pf[s+1] <= pf[s];
      end
    end
  end

  assign mag   = pm[SqrtSteps];
  assign flags = pf[SqrtSteps];
  assign root  = (res[SqrtSteps] == '0) ? RootW'(1) : res[SqrtSteps];

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Depth-2:0], in_valid};
    end
  end
  assign out_valid = v[Depth-1];

endmodule

// ===== hdl/qmn_divide.sv =====
// ----------------------------------------------------------------------------
// qmn_divide: rounded division of each magnitude by the root
// Restoring division, one quotient bit per stage for all four lanes, then
// the sign is applied and zero norm forces the result to zero.
// ----------------------------------------------------------------------------
module qmn_divide import qmn_pkg::*; #(
  parameter int CompW = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [4*MagW-1:0]    in_mag,
  input  qmn_flags_t           in_flags,
  input  logic [RootW-1:0]     in_root,
  output logic                 out_valid,
  output logic [4*FieldW:0]    out_data
);

  localparam int FracBits = CompW - 2;
  // Dividend: mag * 2^FracBits + root/2, below 2^(MagW+FracBits+1)
  localparam int NumW  = MagW + FracBits + 1;
  // Quotient never exceeds 2^FracBits
  localparam int QW    = FracBits + 1;
  localparam int Steps = QW;
  localparam int Depth = Steps + 2;
  localparam int RemW  = RootW + 1;

  logic [NumW-1:0]  num  [Steps+1][4];
  logic [RemW-1:0]  rem  [Steps+1][4];
  logic [QW-1:0]    quo  [Steps+1][4];
  logic [RootW-1:0] d    [Steps+1];
  qmn_flags_t       f    [Steps+1];
  logic [Depth-1:0] v;

  // Form the rounded dividends
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num[0][i] <= (NumW'(in_mag[i*MagW +: MagW]) << FracBits) + NumW'(in_root >> 1);
        rem[0][i] <= '0;
        quo[0][i] <= '0;
      end
      d[0] <= in_root;
      f[0] <= in_flags;
    end
  end

  // One quotient bit per stage; the bits above the quotient width leave a
  // partial remainder below the divisor, so they are shifted in first
  for (genvar s = 0; s < Steps; s++) begin : g_step
    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [RemW:0] part;
      logic [RemW:0] diff;
      if (s == 0) begin : g_first
        // High dividend bits above the quotient are below the divisor
        assign part = {1'b0, RemW'(num[s][i] >> QW)} << 1 |
                      (RemW+1)'(num[s][i][QW-1]);
      end else begin : g_rest
        assign part = {rem[s][i], num[s][i][QW-1-s]};
      end
      assign diff = part - {2'b0, d[s]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (!diff[RemW]) begin
            rem[s+1][i] <= RemW'(diff);
            quo[s+1][i] <= {quo[s][i][QW-2:0], 1'b1};
          end else begin
            rem[s+1][i] <= RemW'(part);
            quo[s+1][i] <= {quo[s][i][QW-2:0], 1'b0};
          end
          num[s+1][i] <= num[s][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d[s+1] <= d[s];
        f[s+1] <= f[s];
      end
    end
  end

  // Apply signs, force zero on zero norm
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (f[Steps].zero)
          out_data[i*FieldW +: FieldW] <= '0;
        else if (f[Steps].neg[i])
          out_data[i*FieldW +: FieldW] <= FieldW'(0) - FieldW'(quo[Steps][i]);
        else
          out_data[i*FieldW +: FieldW] <= FieldW'(quo[Steps][i]);
      end
      out_data[4*FieldW] <= f[Steps].zero;
    end
  end

  // Valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[Depth-2:0], in_valid};
    end
  end
  assign out_valid = v[Depth-1];

endmodule

// ===== hdl/quaternion_multiply_normalize.sv =====
// Throughput: one request per cycle while the skid slot is free; the root and
// division are unrolled into one stage per result bit, which sets the depth.
// A stalled output fills the skid slot, and a full skid slot holds the whole
// pipeline; a skid register keeps ready registered. Reset clears all valid
// bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize: normalized Hamilton product now * old
// Product, block scaling, integer square root and rounded division.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize import qmn_pkg::*; #(
  parameter int COMP_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // now_w, now_x, now_y, now_z, old_w, old_x, old_y, old_z (32 bits each)
  input  logic [8*FieldW-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // res_w, res_x, res_y, res_z (32 bits each)
  output logic [4*FieldW-1:0] m_tdata,
  // zero_norm
  output logic                m_tuser
);

  logic              en;
  logic              pv, sv, dv;
  logic [4*MagW-1:0] pmag, smag;
  qmn_flags_t        pflags, sflags;
  logic [RootW-1:0]  root;
  logic [4*FieldW:0] ddata;
  logic              skid_valid;
  logic [4*FieldW:0] skid_data;
  logic              out_valid;
  logic [4*FieldW:0] out_data;

  // Advance the pipeline while the skid slot is free
  assign en       = !skid_valid;
  assign s_tready = en;

  qmn_product #(.CompW(COMP_WIDTH)) u_product (
    .clk, .rst, .en,
    .in_valid (s_tvalid && s_tready),
    .in_data  (s_tdata),
    .out_valid(pv),
    .mag      (pmag),
    .flags    (pflags)
  );

  qmn_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid (pv),
    .in_mag   (pmag),
    .in_flags (pflags),
    .out_valid(sv),
    .mag      (smag),
    .flags    (sflags),
    .root     (root)
  );

  qmn_divide #(.CompW(COMP_WIDTH)) u_divide (
    .clk, .rst, .en,
    .in_valid (sv),
    .in_mag   (smag),
    .in_flags (sflags),
    .in_root  (root),
    .out_valid(dv),
    .out_data (ddata)
  );

  // Output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= en && dv;
        end
      end else if (en && dv) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_data <= skid_valid ? skid_data : ddata;
    end else if (en && dv) begin
      skid_data <= ddata;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data[4*FieldW-1:0];
  assign m_tuser  = out_data[4*FieldW];

  // Skid slot only fills while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready))
    else $error("skid filled without a stall");

  // A full skid slot blocks new requests
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !s_tready)
    else $error("request accepted with full skid slot");

  // Zero norm results carry zero components
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("zero norm with nonzero components");

endmodule

// ===== sim/quaternion_multiply_normalize_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_tb: self-checking bench for the normalized
// quaternion product
// Drives quaternion pairs through the input stream with random gaps, predicts
// each normalized product with exact integer arithmetic, and compares every
// result field against the oldest prediction.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize_tb;
  import qmn_pkg::*;

  localparam int CompW    = 32;
  localparam int FracW    = CompW - 2;
  localparam int NumRand  = 1430;
  localparam int Latency  = CompW + 40;
  localparam int IdleMax  = 20000;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
    logic [31:0] w;
  } quat_t;

  typedef struct packed {
    logic        zero_norm;
    logic [31:0] res_z;
    logic [31:0] res_y;
    logic [31:0] res_x;
    logic [31:0] res_w;
  } norm_prod_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [8*FieldW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [4*FieldW-1:0] m_tdata;
  logic m_tuser;

  logic [8*FieldW-1:0] pending_reqs[$];
  norm_prod_t          expected_prods[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  quiet_tail = 1'b0;
  bit  hold_send = 1'b0;

  quaternion_multiply_normalize #(.COMP_WIDTH(CompW)) u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Exact product term divided by 4, rounded toward minus infinity
  function automatic longint quarter(longint a, longint b);
    return (a * b) >>> 2;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic norm_prod_t predict_product(logic [8*FieldW-1:0] req);
    quat_t       qn;
    quat_t       qo;
    longint      a[4];
    longint      b[4];
    longint      p[4];
    logic [63:0] mag[4];
    logic [63:0] top;
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] q;
    logic [31:0] res[4];
    int          blen;
    norm_prod_t  out;
    qn = req[127:0];
    qo = req[255:128];
    a[0] = longint'(signed'(qn.w)); a[1] = longint'(signed'(qn.x));
    a[2] = longint'(signed'(qn.y)); a[3] = longint'(signed'(qn.z));
    b[0] = longint'(signed'(qo.w)); b[1] = longint'(signed'(qo.x));
    b[2] = longint'(signed'(qo.y)); b[3] = longint'(signed'(qo.z));
    p[0] = quarter(a[0], b[0]) - quarter(a[1], b[1]) - quarter(a[2], b[2])
         - quarter(a[3], b[3]);
    p[1] = quarter(a[0], b[1]) + quarter(a[1], b[0]) + quarter(a[2], b[3])
         - quarter(a[3], b[2]);
    p[2] = quarter(a[0], b[2]) - quarter(a[1], b[3]) + quarter(a[2], b[0])
         + quarter(a[3], b[1]);
    p[3] = quarter(a[0], b[3]) + quarter(a[1], b[2]) - quarter(a[2], b[1])
         + quarter(a[3], b[0]);
    top = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = (p[i] < 0) ? -p[i] : p[i];
      if (mag[i] > top) top = mag[i];
    end
    out = '0;
    if (top == 0) begin
      out.zero_norm = 1'b1;
      return out;
    end
    blen = 0;
    while (blen < 64 && (top >> blen) != 0) blen++;
    // Scale so the largest magnitude has exactly 31 bits
    sq = '0;
    for (int i = 0; i < 4; i++) begin
      if (blen < 31) mag[i] = mag[i] << (31 - blen);
      else if (blen > 31) mag[i] = mag[i] >> (blen - 31);
      sq = sq + mag[i] * mag[i];
    end
    root = floor_sqrt(sq);
    if (root == 0) root = 1;
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << FracW) + (root >> 1)) / root;
      res[i] = (p[i] < 0) ? 32'(-q) : q[31:0];
    end
    out.res_w = res[0];
    out.res_x = res[1];
    out.res_y = res[2];
    out.res_z = res[3];
    return out;
  endfunction

  function automatic logic [31:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h4000_0000;
      3: return 32'hc000_0000;
      4: return 32'(int'($urandom_range(0, 6)) - 3);
      5: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [8*FieldW-1:0] rand_req();
    logic [8*FieldW-1:0] req;
    for (int i = 0; i < 8; i++) req[32*i +: 32] = pick_comp();
    // Zero one quaternion now and then to hit the zero-norm path
    if ($urandom_range(0, 30) == 0) req[127:0] = '0;
    return req;
  endfunction

  function automatic logic [8*FieldW-1:0] pack_req(quat_t qn, quat_t qo);
    return {qo, qn};
  endfunction

  // Fill the request queue: directed corners, then random pairs
  initial begin
    quat_t one_q;
    quat_t zero_q;
    quat_t max_q;
    quat_t min_q;
    one_q  = '{z: 0, y: 0, x: 0, w: 32'h4000_0000};
    zero_q = '0;
    max_q  = '{z: 32'h7fff_ffff, y: 32'h7fff_ffff, x: 32'h7fff_ffff, w: 32'h7fff_ffff};
    min_q  = '{z: 32'h8000_0000, y: 32'h8000_0000, x: 32'h8000_0000, w: 32'h8000_0000};
    pending_reqs.push_back(pack_req(one_q, one_q));
    pending_reqs.push_back(pack_req(zero_q, one_q));
    pending_reqs.push_back(pack_req(one_q, zero_q));
    pending_reqs.push_back(pack_req(zero_q, zero_q));
    pending_reqs.push_back(pack_req(max_q, max_q));
    pending_reqs.push_back(pack_req(min_q, min_q));
    pending_reqs.push_back(pack_req(max_q, min_q));
    pending_reqs.push_back({8{32'hffff_ffff}});
    pending_reqs.push_back({8{32'h0000_0001}});
    pending_reqs.push_back({32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
    pending_reqs.push_back({32'h0, 32'h0, 32'h0, 32'h3, 32'h0, 32'h0, 32'h0, 32'hffff_fffd});
    pending_reqs.push_back({32'h7fff_ffff, 96'h0, 32'h0000_0001, 96'h0});
    pending_reqs.push_back({96'h0, 32'h8000_0000, 96'h0, 32'h0000_0001});
    pending_reqs.push_back({32'h0, 32'h4000_0000, 64'h0, 32'h0, 32'h0, 32'h4000_0000, 32'h0});
    pending_reqs.push_back({$urandom(), 224'h0});
    pending_reqs.push_back({8{32'haaaa_aaaa}});
    pending_reqs.push_back({8{32'h5555_5555}});
    for (int i = 0; i < NumRand; i++) pending_reqs.push_back(rand_req());
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // Drive requests with random bursts of gaps; drain fully once mid-run
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_prods.push_back(predict_product(s_tdata));
        void'(pending_reqs.pop_front());
        if (pending_reqs.size() == 700) hold_send <= 1'b1;
      end
      if (hold_send && expected_prods.size() == 0 && !(s_tvalid && s_tready))
        hold_send <= 1'b0;
      if (pending_reqs.size() < 200) quiet_tail <= 1'b1;
      if (s_tvalid && !s_tready) begin
        // hold the request
      end else if (pending_reqs.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (hold_send || (s_tvalid && s_tready && pending_reqs.size() == 700)) begin
        s_tvalid <= 1'b0;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 6);
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_reqs[0];
      end
    end
  end

  // Receive side stalls in bursts too
  always @(posedge clk) begin
    if (!rst) begin
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    norm_prod_t got;
    norm_prod_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (expected_prods.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_prods.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want w=%h x=%h y=%h z=%h zn=%b, got w=%h x=%h y=%h z=%h zn=%b",
                     want.res_w, want.res_x, want.res_y, want.res_z, want.zero_norm,
                     got.res_w, got.res_x, got.res_y, got.res_z, got.zero_norm);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleMax) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Wait for the drain, then keep watching for stray results
  initial begin
    wait (!rst);
    wait (pending_reqs.size() == 0 && expected_prods.size() == 0);
    repeat (2 * Latency) @(posedge clk);
    if (mismatches == 0 && expected_prods.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
